### rtl/bsfc_pkg.sv
// Shared types, constants and helper functions for the bitmap set/find/count engine.
`timescale 1ns / 1ps
package bsfc_pkg;

  localparam int unsigned MaxItems  = 4096;
  localparam int unsigned WordBits  = 32;
  localparam int unsigned IdxW      = 12;
  localparam int unsigned CntW      = 13;

  typedef enum logic [2:0] {
    KIND_SET       = 3'd0,
    KIND_CLEAR     = 3'd1,
    KIND_FIND      = 3'd2,
    KIND_COUNT     = 3'd3,
    KIND_ANY       = 3'd4,
    KIND_CLR_RANGE = 3'd5,
    KIND_CLR_ALL   = 3'd6,
    KIND_SET_ALL   = 3'd7
  } kind_t;

  typedef struct packed {
    logic [2:0]      kind;
    logic [IdxW-1:0] first_index;
    logic [IdxW-1:0] last_index;
  } req_t;

  typedef struct packed {
    logic            changed;
    logic            found_valid;
    logic [IdxW-1:0] found_index;
    logic [CntW-1:0] range_count;
    logic            any_set;
    logic            index_error;
    logic [CntW-1:0] total_set;
  } rsp_t;

  // Population count of one word.
  function automatic logic [5:0] pop32(input logic [WordBits-1:0] x);
    logic [5:0] c;
    c = '0;
    for (int i = 0; i < WordBits; i++) c = c + {5'd0, x[i]};
    return c;
  endfunction

  // Position of the first set bit counting from the MSB.
  function automatic logic [4:0] lead_zeros(input logic [WordBits-1:0] x);
    logic [4:0] c;
    c = '0;
    for (int i = 0; i < WordBits; i++) begin
      if (x[i]) c = 5'(WordBits - 1 - i);
    end
    return c;
  endfunction

endpackage

### rtl/bsfc_ram.sv
// Generic RAM with one write port, one read port and registered read.
`timescale 1ns / 1ps
module bsfc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### rtl/bitmap_set_find_count_engine.sv
// Top level of the bitmap set/find/count engine.
`timescale 1ns / 1ps
// One command per start pulse while busy is low; exactly one result comes back on
// out_valid for one cycle and cannot be stalled. Bits live in a RAM of MaxItems/32
// words, walked by a shared mask/popcount unit that takes each word through address,
// read wait, and evaluate and write back. Busy stays high from start to the result,
// and the result appears in the cycle busy drops: set and clear visit one word;
// find/count/any/clear-range walk the words of their range, find stopping at its
// first hit; set-all and clear-all sweep every word. A rejected command visits none.
// After reset a clearing pass zeroes every RAM word with busy high.
module bitmap_set_find_count_engine
  import bsfc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  req_t            in_req,
  output logic            out_valid,
  output rsp_t            out_rsp,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [CntW-1:0] cfg_item_count
);
  localparam int unsigned Words = (MaxItems + WordBits - 1) / WordBits;
  localparam int unsigned AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int unsigned NW    = $clog2(MaxItems + 1);
  localparam int unsigned WW    = AW + 1;

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_READ, ST_WAIT, ST_EVAL, ST_DONE
  } state_t;

  state_t          state_r;
  logic [CntW-1:0] item_count_r;
  logic [NW-1:0]   n_r;
  logic [2:0]      kind_r;
  logic [NW-1:0]   lo_r, hi_r;
  logic [WW-1:0]   w_r, w_end_r;
  logic [NW-1:0]   pop_r;
  logic [CntW-1:0] rcount_r;
  logic            fvalid_r, any_r, changed_r;
  logic [NW-1:0]   findex_r;
  rsp_t            rsp_r;
  logic            out_valid_r;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [WordBits-1:0] ram_wdata, ram_rdata;

  bsfc_ram #(.WIDTH(WordBits), .DEPTH(Words)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // effective item count
  logic [NW-1:0] n_eff;
  always_comb begin
    if ({19'd0, item_count_r} > 32'(MaxItems)) n_eff = NW'(MaxItems);
    else n_eff = NW'(item_count_r);
  end

  // shared word unit: mask of [lo_r,hi_r] in word w_r
  logic [WW-1:0]       lo_w, hi_w;
  logic [4:0]          s_bit, e_bit;
  logic [WordBits-1:0] span, hit, wmask;
  logic [5:0]          hit_pop, set_fill;
  logic [NW+5:0]       wbase;
  always_comb begin
    lo_w  = WW'(lo_r >> 5);
    hi_w  = WW'(hi_r >> 5);
    s_bit = (w_r == lo_w) ? lo_r[4:0] : 5'd0;
    e_bit = (w_r == hi_w) ? hi_r[4:0] : 5'd31;
    span  = (32'hFFFF_FFFF >> s_bit) & (32'hFFFF_FFFF << (5'd31 - e_bit));
    hit   = ram_rdata & span;
    hit_pop = pop32(hit);
    wbase = (NW+6)'(w_r) << 5;
    // set-all word fill
    if (wbase + 32 <= (NW+6)'(n_r)) set_fill = 6'd32;
    else if (wbase < (NW+6)'(n_r)) set_fill = 6'((NW+6)'(n_r) - wbase);
    else set_fill = 6'd0;
    wmask = (set_fill == 6'd0) ? '0 : (32'hFFFF_FFFF << (6'd32 - set_fill));
  end

  logic [IdxW-1:0] f_i, l_i;
  logic [NW-1:0]   f_n, l_n, l_clamp;
  assign f_i = in_req.first_index;
  assign l_i = in_req.last_index;
  assign f_n = NW'(f_i);
  assign l_n = NW'(l_i);
  assign l_clamp = ({20'd0, l_i} + 32'd1 > 32'(n_eff)) ? n_eff - NW'(1) : l_n;

  // error flag of the incoming command
  logic idx_err;
  always_comb begin
    unique case (kind_t'(in_req.kind))
      KIND_SET, KIND_CLEAR, KIND_FIND:
        idx_err = f_n >= n_eff;
      KIND_COUNT:
        idx_err = (n_eff == '0) || (l_clamp < f_n);
      KIND_ANY, KIND_CLR_RANGE:
        idx_err = f_n >= n_eff || l_n >= n_eff || f_i > l_i;
      default: idx_err = 1'b0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(w_r);
    ram_wdata = '0;
    ram_raddr = AW'(w_r);
    if (state_r == ST_INIT) begin
      ram_we = 1'b1;
    end else if (state_r == ST_EVAL) begin
      unique case (kind_t'(kind_r))
        KIND_SET:       begin ram_we = hit == 0; ram_wdata = ram_rdata | span; end
        KIND_CLEAR:     begin ram_we = hit != 0; ram_wdata = ram_rdata & ~span; end
        KIND_CLR_RANGE: begin ram_we = 1'b1; ram_wdata = ram_rdata & ~hit; end
        KIND_CLR_ALL:   begin ram_we = 1'b1; ram_wdata = '0; end
        KIND_SET_ALL:   begin ram_we = 1'b1; ram_wdata = wmask; end
        default:        ram_we = 1'b0;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      item_count_r <= CntW'(4096);
      pop_r        <= '0;
      w_r          <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= (state_r == ST_DONE);
      if (cfg_valid) item_count_r <= cfg_item_count;
      unique case (state_r)
        ST_INIT: begin
          if (w_r == WW'(Words - 1)) begin
            state_r <= ST_IDLE;
          end
          w_r <= w_r + WW'(1);
        end
        ST_IDLE: begin
          if (start) begin
            kind_r    <= in_req.kind;
            n_r       <= n_eff;
            rcount_r  <= '0;
            fvalid_r  <= 1'b0;
            findex_r  <= '0;
            any_r     <= 1'b0;
            changed_r <= 1'b0;
            rsp_r.index_error <= idx_err;
            unique case (kind_t'(in_req.kind))
              KIND_SET, KIND_CLEAR: begin
                lo_r    <= f_n;
                hi_r    <= f_n;
                w_r     <= WW'(f_i >> 5);
                w_end_r <= WW'(f_i >> 5);
                state_r <= (f_n >= n_eff) ? ST_DONE : ST_READ;
              end
              KIND_FIND: begin
                lo_r    <= f_n;
                hi_r    <= n_eff - NW'(1);
                w_r     <= WW'(f_i >> 5);
                w_end_r <= WW'((n_eff - NW'(1)) >> 5);
                state_r <= (f_n >= n_eff) ? ST_DONE : ST_READ;
              end
              KIND_COUNT: begin
                lo_r    <= f_n;
                hi_r    <= l_clamp;
                w_r     <= WW'(f_i >> 5);
                w_end_r <= WW'(l_clamp >> 5);
                state_r <= (n_eff == '0 || l_clamp < f_n) ? ST_DONE : ST_READ;
              end
              KIND_ANY, KIND_CLR_RANGE: begin
                lo_r    <= f_n;
                hi_r    <= l_n;
                w_r     <= WW'(f_i >> 5);
                w_end_r <= WW'(l_i >> 5);
                state_r <= (f_n >= n_eff || l_n >= n_eff || f_i > l_i) ?
                           ST_DONE : ST_READ;
              end
              default: begin
                // whole-array sweep
                lo_r    <= '0;
                hi_r    <= NW'(MaxItems - 1);
                w_r     <= '0;
                w_end_r <= WW'(Words - 1);
                state_r <= ST_READ;
              end
            endcase
          end
        end
        ST_READ: state_r <= ST_WAIT;
        ST_WAIT: state_r <= ST_EVAL;
        ST_EVAL: begin
          unique case (kind_t'(kind_r))
            KIND_SET:   if (hit == 0) begin pop_r <= pop_r + NW'(1); changed_r <= 1'b1; end
            KIND_CLEAR: if (hit != 0) begin pop_r <= pop_r - NW'(1); changed_r <= 1'b1; end
            KIND_FIND: if (hit != 0 && !fvalid_r) begin
              fvalid_r <= 1'b1;
              findex_r <= NW'(wbase) + NW'(lead_zeros(hit));
            end
            KIND_COUNT: rcount_r <= rcount_r + CntW'(hit_pop);
            KIND_ANY:   if (hit != 0) any_r <= 1'b1;
            KIND_CLR_RANGE: pop_r <= pop_r - NW'(hit_pop);
            KIND_CLR_ALL:   pop_r <= '0;
            KIND_SET_ALL:   pop_r <= n_r;
            default: ;
          endcase
          if (w_r == w_end_r || (kind_r == KIND_FIND && hit != 0)) begin
            state_r <= ST_DONE;
          end else begin
            w_r     <= w_r + WW'(1);
            state_r <= ST_READ;
          end
        end
        ST_DONE: begin
          rsp_r.changed     <= changed_r;
          rsp_r.found_valid <= fvalid_r;
          rsp_r.found_index <= IdxW'(findex_r);
          rsp_r.range_count <= rcount_r;
          rsp_r.any_set     <= any_r;
          rsp_r.total_set   <= CntW'(pop_r);
          state_r           <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end
endmodule

### bench/bsfc_checker.sv
// Checker for the bitmap engine: predicts each command's result and compares.
`timescale 1ns / 1ps
module bsfc_checker
  import bsfc_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            busy,
  input  req_t            in_req,
  input  logic            out_valid,
  input  rsp_t            out_rsp,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [CntW-1:0] cfg_item_count,
  output int              fail_count,
  output int              pending
);
  localparam int Words = 128;

  logic [31:0]     bits_q [Words];
  logic [CntW-1:0] pop_q;
  logic [CntW-1:0] limit_q;
  rsp_t            expected_q [$];

  // Mask of word w within [lo, hi].
  function automatic logic [31:0] span(int w, int lo, int hi);
    int s;
    int e;
    s = (w == lo / 32) ? lo % 32 : 0;
    e = (w == hi / 32) ? hi % 32 : 31;
    return (32'hFFFF_FFFF >> s) & (32'hFFFF_FFFF << (31 - e));
  endfunction

  function automatic int ones(logic [31:0] x);
    int c;
    c = 0;
    for (int i = 0; i < 32; i++) c += x[i];
    return c;
  endfunction

  function automatic rsp_t apply_command(req_t r);
    rsp_t o;
    int n;
    int f;
    int l;
    int w;
    logic [31:0] m;
    logic [31:0] hit;
    o = '0;
    n = (limit_q > 4096) ? 4096 : limit_q;
    f = r.first_index;
    l = r.last_index;
    case (kind_t'(r.kind))
      KIND_SET, KIND_CLEAR: begin
        if (f >= n) o.index_error = 1'b1;
        else begin
          w = f / 32;
          m = 32'h8000_0000 >> (f % 32);
          if (r.kind == KIND_SET && (bits_q[w] & m) == 0) begin
            bits_q[w] |= m;
            pop_q++;
            o.changed = 1'b1;
          end else if (r.kind == KIND_CLEAR && (bits_q[w] & m) != 0) begin
            bits_q[w] &= ~m;
            pop_q--;
            o.changed = 1'b1;
          end
        end
      end
      KIND_FIND: begin
        if (f >= n) o.index_error = 1'b1;
        else begin
          for (w = f / 32; w <= (n - 1) / 32; w++) begin
            hit = bits_q[w] & span(w, f, n - 1);
            if (hit != 0) begin
              o.found_valid = 1'b1;
              for (int b = 31; b >= 0; b--)
                if (hit[b]) begin
                  o.found_index = IdxW'(w * 32 + 31 - b);
                  break;
                end
              break;
            end
          end
        end
      end
      KIND_COUNT: begin
        if (n == 0) o.index_error = 1'b1;
        else begin
          if (l > n - 1) l = n - 1;
          if (l < f) o.index_error = 1'b1;
          else
            for (w = f / 32; w <= l / 32; w++)
              o.range_count += CntW'(ones(bits_q[w] & span(w, f, l)));
        end
      end
      KIND_ANY, KIND_CLR_RANGE: begin
        if (f >= n || l >= n || f > l) o.index_error = 1'b1;
        else
          for (w = f / 32; w <= l / 32; w++) begin
            hit = bits_q[w] & span(w, f, l);
            if (r.kind == KIND_ANY) begin
              if (hit != 0) o.any_set = 1'b1;
            end else begin
              bits_q[w] &= ~hit;
              pop_q -= CntW'(ones(hit));
            end
          end
      end
      KIND_CLR_ALL: begin
        for (w = 0; w < Words; w++) bits_q[w] = '0;
        pop_q = '0;
      end
      default: begin
        for (w = 0; w < Words; w++) begin
          if (w * 32 + 32 <= n) bits_q[w] = '1;
          else if (w * 32 < n) bits_q[w] = 32'hFFFF_FFFF << (32 - (n - w * 32));
          else bits_q[w] = '0;
        end
        pop_q = CntW'(n);
      end
    endcase
    o.total_set = pop_q;
    return o;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (!rst_n) begin
      pop_q = '0;
      limit_q = 13'd4096;
      for (int w = 0; w < Words; w++) bits_q[w] = '0;
      expected_q.delete();
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) report("unexpected beat", 1, 0);
        else begin
          e = expected_q.pop_front();
          if (out_rsp.changed !== e.changed) report("changed", out_rsp.changed, e.changed);
          if (out_rsp.found_valid !== e.found_valid)
            report("found_valid", out_rsp.found_valid, e.found_valid);
          if (out_rsp.found_index !== e.found_index)
            report("found_index", out_rsp.found_index, e.found_index);
          if (out_rsp.range_count !== e.range_count)
            report("range_count", out_rsp.range_count, e.range_count);
          if (out_rsp.any_set !== e.any_set) report("any_set", out_rsp.any_set, e.any_set);
          if (out_rsp.index_error !== e.index_error)
            report("index_error", out_rsp.index_error, e.index_error);
          if (out_rsp.total_set !== e.total_set)
            report("total_set", out_rsp.total_set, e.total_set);
        end
      end
      if (start && !busy) expected_q.push_back(apply_command(in_req));
      if (cfg_valid && cfg_ready) limit_q = cfg_item_count;
    end
    pending = expected_q.size();
  end
endmodule

### bench/testbench.sv
// Top of the bitmap engine bench: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
  import bsfc_pkg::*;

  localparam int WatchLimit = 40000;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  req_t            in_req;
  logic            out_valid;
  rsp_t            out_rsp;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [CntW-1:0] cfg_item_count;
  int              fail_count;
  int              pending;
  int              idle_pct;
  int              quiet_cycles;
  int              sent;
  int              n_now;

  bitmap_set_find_count_engine dut (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_rsp,
    .cfg_valid, .cfg_ready, .cfg_item_count
  );

  bsfc_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_rsp,
    .cfg_valid, .cfg_ready, .cfg_item_count, .fail_count, .pending
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: count cycles with no beat on any channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready) || !rst_n)
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("watchdog expired, %0d results outstanding", pending);
      $display("status: fail");
      $finish;
    end
  end

  // Called at a falling edge; busy is stable there and holds through the next rise.
  task automatic issue(kind_t k, int f, int l);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    while (busy) @(negedge clk);
    start <= 1'b1;
    in_req <= '{kind: k, first_index: IdxW'(f), last_index: IdxW'(l)};
    @(negedge clk);
    start <= 1'b0;
    in_req <= '{kind: kind_t'($urandom_range(7)), first_index: IdxW'($urandom),
                last_index: IdxW'($urandom)};
    sent++;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    // let any last write-back finish
    repeat (300) @(negedge clk);
  endtask

  task automatic write_count(int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_item_count <= CntW'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_now = (v > 4096) ? 4096 : v;
  endtask

  // Random index biased toward the valid span, with some out-of-range noise.
  function automatic int pick_index();
    if (n_now > 0 && $urandom_range(9) != 0) return $urandom_range(n_now - 1);
    return $urandom_range(4095);
  endfunction

  task automatic random_phase(int count);
    kind_t k;
    int f;
    int l;
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 30) k = KIND_SET;
      else if (r < 45) k = KIND_CLEAR;
      else if (r < 98) k = kind_t'($urandom_range(2, 5));
      else k = kind_t'($urandom_range(6, 7));
      f = pick_index();
      l = ($urandom_range(3) == 0) ? pick_index() : f + $urandom_range(200);
      if (l > 4095) l = 4095;
      issue(k, f, l);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_valid = 1'b0;
    cfg_item_count = '0;
    idle_pct = 0;
    sent = 0;
    n_now = 4096;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes of both ends and every kind
    issue(KIND_FIND, 0, 0);
    issue(KIND_SET, 0, 0);
    issue(KIND_SET, 0, 0);
    issue(KIND_SET, 4095, 0);
    issue(KIND_SET, 2730, 0);
    issue(KIND_FIND, 1, 0);
    issue(KIND_FIND, 4095, 0);
    issue(KIND_COUNT, 0, 4095);
    issue(KIND_COUNT, 100, 50);
    issue(KIND_ANY, 1, 4094);
    issue(KIND_ANY, 5, 4);
    issue(KIND_ANY, 0, 4095);
    issue(KIND_CLR_RANGE, 1365, 4095);
    issue(KIND_CLEAR, 0, 0);
    issue(KIND_CLEAR, 0, 0);
    issue(KIND_SET_ALL, 0, 0);
    issue(KIND_COUNT, 31, 32);
    issue(KIND_CLR_RANGE, 3, 2);
    issue(KIND_CLR_RANGE, 33, 96);
    issue(KIND_CLR_ALL, 0, 0);

    write_count(40);
    issue(KIND_SET, 40, 40);
    issue(KIND_SET, 39, 39);
    issue(KIND_COUNT, 0, 4095);
    issue(KIND_SET_ALL, 0, 0);
    write_count(0);
    issue(KIND_COUNT, 0, 0);
    issue(KIND_FIND, 0, 0);
    write_count(8191);
    issue(KIND_FIND, 4000, 0);

    // random phases: with and without sender idling
    idle_pct = 0;
    random_phase(150);
    drain();
    idle_pct = 60;
    random_phase(150);
    write_count(77);
    idle_pct = 37;
    random_phase(150);
    write_count(4096);
    idle_pct = 0;
    random_phase(150);
    write_count(1000);
    idle_pct = 60;
    random_phase(100);
    drain();

    $display("covered %0d commands across item counts 0, 40, 77, 1000, 4096 and 8191,",
             sent);
    $display("with sender gaps of 0, 37 and 60 percent");
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

### bitmap_set_find_count_engine.f
rtl/bsfc_pkg.sv
rtl/bsfc_ram.sv
rtl/bitmap_set_find_count_engine.sv
bench/bsfc_checker.sv
bench/testbench.sv
